### rtl/swrs_pkg.sv
// Shared types and constants for the stop-and-wait request sender.
// No dependencies; imported by swrs_engine and stop_and_wait_request_sender.
package swrs_pkg;

   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_ADDR_W-1:0] CSR_TIMEOUT_TICKS = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_ATTEMPTS  = 1'd1;

   localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd10;
   localparam logic [15:0] MAX_ATTEMPTS_RESET  = 16'd20000;
   localparam logic [31:0] SEQ_RESET           = 32'd1;

   localparam logic [1:0] MODE_CMD  = 2'd0;
   localparam logic [1:0] MODE_PKT  = 2'd1;
   localparam logic [1:0] MODE_TICK = 2'd2;

   localparam logic [1:0] KIND_TX   = 2'd0;
   localparam logic [1:0] KIND_OK   = 2'd1;
   localparam logic [1:0] KIND_FAIL = 2'd2;
   localparam logic [1:0] KIND_BUSY = 2'd3;

   typedef struct packed {
      logic [1:0]         mode;
      logic [31:0]        dest_ip;
      logic [31:0]        amount;
      logic               pkt_is_req_ack;
      logic [31:0]        pkt_seqn;
      logic signed [31:0] pkt_balance;
   } req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [31:0]        tx_seqn;
      logic [31:0]        tx_dest;
      logic [31:0]        tx_amount;
      logic signed [31:0] balance;
   } rsp_type;

   typedef struct packed {
      logic [15:0] timeout_ticks;
      logic [15:0] max_attempts;
   } cfg_type;

endpackage

### rtl/stop_and_wait_request_sender.sv
// Stop-and-wait request sender, top level. Depends on swrs_pkg, swrs_engine.
// An accepted transaction is held in the input register, then its result in the
// result register. Throughput: one transaction per cycle while results are
// taken; a stalled result holds one more transaction in the input register.
// Reset (synchronous, active high): idle, sequence 1, timeout 10 ticks,
// 20000 attempts; input and result registers empty.
module stop_and_wait_request_sender (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  swrs_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output swrs_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [swrs_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [swrs_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import swrs_pkg::*;

   cfg_type cfg_ff;
   req_type stage_ff;
   logic    stage_valid_ff;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;

   logic    step;
   logic    emit;
   rsp_type result;

   // stage moves on when the result register is free or being drained
   assign step      = stage_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !stage_valid_ff || step;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ticks <= TIMEOUT_TICKS_RESET;
         cfg_ff.max_attempts  <= MAX_ATTEMPTS_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_TIMEOUT_TICKS: cfg_ff.timeout_ticks <= csr_wdata;
            CSR_MAX_ATTEMPTS:  cfg_ff.max_attempts  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_ready) begin
         stage_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         stage_ff <= req_data;
      end
   end

   swrs_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (stage_ff),
      .cfg    (cfg_ff),
      .emit   (emit),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= emit;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && emit) begin
         rsp_ff <= result;
      end
   end

`ifndef SYNTHESIS
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !stage_valid_ff)
      else $error("pipeline not empty after reset");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("input taken while stage is blocked");

   a_balance_only_on_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.kind != KIND_OK) |-> rsp_data.balance == 32'sd0)
      else $error("nonzero balance on non-success result");
`endif

endmodule

### rtl/swrs_engine.sv
// Protocol state and next-state logic of the stop-and-wait sender.
// Depends on swrs_pkg.
module swrs_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  swrs_pkg::req_type item,
   input  swrs_pkg::cfg_type cfg,
   output logic             emit,
   output swrs_pkg::rsp_type result
);
   import swrs_pkg::*;

   logic        waiting_ff, waiting_in;
   logic [31:0] next_seq_ff, next_seq_in;
   logic [15:0] attempts_ff, attempts_in;
   logic [15:0] timer_ff, timer_in;
   logic [31:0] held_dest_ff, held_dest_in;
   logic [31:0] held_amount_ff, held_amount_in;

   logic [15:0] tick_next;
   logic [15:0] limit;
   logic        exhausted;
   logic        retry;

   assign tick_next = timer_ff + 16'd1;
   assign limit     = (cfg.timeout_ticks == 16'd0) ? 16'd1 : cfg.timeout_ticks;
   assign exhausted = attempts_ff >= cfg.max_attempts;

   always_comb begin
      waiting_in     = waiting_ff;
      next_seq_in    = next_seq_ff;
      attempts_in    = attempts_ff;
      timer_in       = timer_ff;
      held_dest_in   = held_dest_ff;
      held_amount_in = held_amount_ff;
      retry          = 1'b0;
      emit           = 1'b0;
      result.kind      = KIND_TX;
      result.tx_seqn   = next_seq_ff;
      result.tx_dest   = held_dest_ff;
      result.tx_amount = held_amount_ff;
      result.balance   = '0;

      unique case (item.mode)
         MODE_CMD: begin
            emit             = 1'b1;
            result.tx_dest   = item.dest_ip;
            result.tx_amount = item.amount;
            if (waiting_ff) begin
               result.kind = KIND_BUSY;
            end else begin
               waiting_in     = 1'b1;
               held_dest_in   = item.dest_ip;
               held_amount_in = item.amount;
               attempts_in    = 16'd1;
               timer_in       = '0;
            end
         end
         MODE_PKT: begin
            if (waiting_ff) begin
               if (item.pkt_is_req_ack && item.pkt_seqn == next_seq_ff) begin
                  emit           = 1'b1;
                  result.kind    = KIND_OK;
                  result.balance = item.pkt_balance;
                  waiting_in     = 1'b0;
                  timer_in       = '0;
                  next_seq_in    = next_seq_ff + 32'd1;
               end else begin
                  retry = 1'b1;
               end
            end
         end
         MODE_TICK: begin
            if (waiting_ff) begin
               timer_in = tick_next;
               retry    = tick_next >= limit;
            end
         end
         default: ;
      endcase

      // a used-up attempt either resends the held request or gives up
      if (retry) begin
         emit     = 1'b1;
         timer_in = '0;
         if (exhausted) begin
            result.kind = KIND_FAIL;
            waiting_in  = 1'b0;
         end else begin
            attempts_in = attempts_ff + 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         waiting_ff  <= 1'b0;
         next_seq_ff <= SEQ_RESET;
         attempts_ff <= '0;
         timer_ff    <= '0;
      end else if (step) begin
         waiting_ff  <= waiting_in;
         next_seq_ff <= next_seq_in;
         attempts_ff <= attempts_in;
         timer_ff    <= timer_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         held_dest_ff   <= held_dest_in;
         held_amount_ff <= held_amount_in;
      end
   end

endmodule
